// ===== hdl/assert_macros.svh =====
// Assertion macros used by the tag stripper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HTS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HTS_ASSERT(label, clk, rst, prop, msg)
`define HTS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/htmlstr_pkg.sv =====
// Types, constants and helpers shared by the tag stripper modules.
package htmlstr_pkg;

   localparam int WINDOW_BYTES = 24;
   localparam int WS_DEPTH     = 32;
   localparam int MIN_LOOK     = 7;
   localparam int STOP_BYTES   = 24;
   localparam int STOP_CAP     = (WINDOW_BYTES < STOP_BYTES) ? WINDOW_BYTES : STOP_BYTES;

   localparam int LEN_W      = 5;
   localparam int CMP_W      = LEN_W + 1;
   localparam int FILL_W     = $clog2(WINDOW_BYTES + 1);
   localparam int WIN_IDX_W  = $clog2(WINDOW_BYTES);
   localparam int WS_CNT_W   = $clog2(WS_DEPTH + 1);
   localparam int WS_IDX_W   = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam int OPEN_LEN  = 6;
   localparam int CLOSE_LEN = 7;
   localparam int QUOT_LEN  = 6;
   localparam int SKIP_W    = $clog2(CLOSE_LEN);

   localparam logic [55:0] HEAD_OPEN_STR  = 56'("<head>");
   localparam logic [55:0] HEAD_CLOSE_STR = 56'("</head>");
   localparam logic [55:0] QUOT_STR       = 56'("&quot;");

   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   typedef enum logic [1:0] {
      REG_STOP_LOW,
      REG_STOP_MID,
      REG_STOP_HIGH,
      REG_STOP_LEN
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
      logic       ws_overflow;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] open_b;
      logic [7:0] close_b;
      logic [7:0] quot_b;
      logic [7:0] stop_b;
   } cell_ref_type;

   typedef struct packed {
      logic open_hit;
      logic close_hit;
      logic quot_hit;
      logic stop_hit;
   } cell_hit_type;

   typedef struct packed {
      logic head_open;
      logic head_close;
      logic quot;
      logic stop;
   } window_match_type;

   function automatic logic [7:0] lit_byte(input logic [55:0] str, input int len, input int i);
      logic [7:0] b;
      b = 8'h00;
      if (i < len) b = str[8*(len-1-i) +: 8];
      return b;
   endfunction

endpackage

// ===== hdl/htmlstr_cell.sv =====
// One lookahead window cell: holds a byte, shifts toward the front, compares against its refs.
module htmlstr_cell import htmlstr_pkg::*; (
   input  logic         clock,
   input  logic         shift,
   input  logic         load,
   input  logic [7:0]   load_byte,
   input  logic [7:0]   next_byte,
   input  cell_ref_type ref_bytes,
   output logic [7:0]   cur_byte,
   output cell_hit_type hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (shift) begin
         byte_in = next_byte;
      end else if (load) begin
         byte_in = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cur_byte      = byte_ff;
   assign hit.open_hit  = (byte_ff == ref_bytes.open_b);
   assign hit.close_hit = (byte_ff == ref_bytes.close_b);
   assign hit.quot_hit  = (byte_ff == ref_bytes.quot_b);
   assign hit.stop_hit  = (byte_ff == ref_bytes.stop_b);

endmodule

// ===== hdl/htmlstr_window.sv =====
// Row of window cells with the pattern match reduction at the front.
module htmlstr_window import htmlstr_pkg::*; (
   input  logic                    clock,
   input  logic                    push,
   input  logic [WIN_IDX_W-1:0]    push_idx,
   input  logic [7:0]              push_byte,
   input  logic                    shift,
   input  logic [FILL_W-1:0]       fill,
   input  logic [LEN_W-1:0]        stop_len,
   input  logic [8*STOP_BYTES-1:0] stop_pattern,
   output logic [7:0]              front_byte,
   output window_match_type        match
);

   logic [7:0]              cur [WINDOW_BYTES];
   cell_hit_type            hit [WINDOW_BYTES];
   logic [WINDOW_BYTES-1:0] stop_ok;
   logic [OPEN_LEN-1:0]     open_ok;
   logic [CLOSE_LEN-1:0]    close_ok;
   logic [QUOT_LEN-1:0]     quot_ok;
   logic [CMP_W-1:0]        fill_cmp;
   logic [CMP_W-1:0]        len_cmp;

   for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
      localparam logic [CMP_W-1:0] POS = CMP_W'(i);
      cell_ref_type refs;
      logic [7:0]   next_b;
      logic         load;

      assign refs.open_b  = lit_byte(HEAD_OPEN_STR, OPEN_LEN, i);
      assign refs.close_b = lit_byte(HEAD_CLOSE_STR, CLOSE_LEN, i);
      assign refs.quot_b  = lit_byte(QUOT_STR, QUOT_LEN, i);

      if (i < STOP_BYTES) begin : g_stop
         assign refs.stop_b = stop_pattern[8*i +: 8];
      end else begin : g_nostop
         assign refs.stop_b = 8'h00;
      end

      if (i == WINDOW_BYTES - 1) begin : g_tail
         assign next_b = 8'h00;
      end else begin : g_link
         assign next_b = cur[i+1];
      end

      assign load = push && (push_idx == WIN_IDX_W'(i));

      htmlstr_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .load      (load),
         .load_byte (push_byte),
         .next_byte (next_b),
         .ref_bytes (refs),
         .cur_byte  (cur[i]),
         .hit       (hit[i])
      );

      assign stop_ok[i] = hit[i].stop_hit || (POS >= len_cmp);

      if (i < OPEN_LEN) begin : g_open
         assign open_ok[i] = hit[i].open_hit;
      end
      if (i < CLOSE_LEN) begin : g_close
         assign close_ok[i] = hit[i].close_hit;
      end
      if (i < QUOT_LEN) begin : g_quot
         assign quot_ok[i] = hit[i].quot_hit;
      end
   end

   assign fill_cmp   = CMP_W'(fill);
   assign len_cmp    = CMP_W'(stop_len);
   assign front_byte = cur[0];

   assign match.head_open  = (fill_cmp >= CMP_W'(OPEN_LEN)) && (&open_ok);
   assign match.head_close = (fill_cmp >= CMP_W'(CLOSE_LEN)) && (&close_ok);
   assign match.quot       = (fill_cmp >= CMP_W'(QUOT_LEN)) && (&quot_ok);
   assign match.stop       = (stop_len != '0) && (len_cmp <= fill_cmp) && (&stop_ok);

endmodule

// ===== hdl/html_tag_stripper.sv =====
// Top level of the HTML tag stripper: config registers, sequencer, whitespace store, output.
// An accepted byte enters the window, then window positions are decided and the item is closed.
// No byte is taken until the item closes; a kept non-space byte is sent after the held spaces.
// A final byte drains the window, up to 24 positions; a stalled output holds the sequencer.
// Reset is synchronous and clears control state and config registers; the space store is not cleared.
`include "assert_macros.svh"

module html_tag_stripper import htmlstr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [SKIP_W-1:0]    skip_ff, skip_in;
   logic                 tag_ff, tag_in;
   logic                 head_ff, head_in;
   logic                 started_ff, started_in;
   logic                 stop_ff, stop_in;
   logic [WS_CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic                 held_valid_ff, held_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   rsp_item_type         held_ff, held_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic [WS_CNT_W-1:0]  flush_idx_ff, flush_idx_in;
   logic [7:0]           flush_char_ff, flush_char_in;
   logic [7:0]           ws_rd_ff;
   logic [7:0]           ws_mem [WS_DEPTH];

   logic [63:0]          stop_low_ff, stop_mid_ff, stop_high_ff;
   logic [LEN_W-1:0]     stop_len_ff;
   csr_reg_type          reg_sel;
   logic                 csr_write;

   logic [LEN_W-1:0]     eff_len;
   logic [LEN_W-1:0]     need;
   logic                 decide_due;
   logic                 out_free;
   logic                 req_accept;
   logic                 win_push;
   logic                 win_shift;
   logic [7:0]           front_byte;
   window_match_type     match;
   logic                 keep;
   logic [7:0]           keep_char;
   logic                 ws_wr;
   logic                 put;
   rsp_item_type         put_item;
   logic                 fwd;
   rsp_item_type         fwd_item;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = csr_reg_type'(paddr[CSR_ADDR_W-1:3]);
   assign pready    = 1'b1;

   always_comb begin
      case (reg_sel)
         REG_STOP_LOW:  prdata = stop_low_ff;
         REG_STOP_MID:  prdata = stop_mid_ff;
         REG_STOP_HIGH: prdata = stop_high_ff;
         REG_STOP_LEN:  prdata = CSR_DATA_W'(stop_len_ff);
         default:       prdata = '0;
      endcase
   end

   assign eff_len = (stop_len_ff > LEN_W'(STOP_CAP)) ? LEN_W'(STOP_CAP) : stop_len_ff;
   assign need    = (eff_len < LEN_W'(MIN_LOOK)) ? LEN_W'(MIN_LOOK) : eff_len;

   assign decide_due = !stop_ff &&
                       ((CMP_W'(fill_ff) >= CMP_W'(need)) || (last_ff && (fill_ff != '0)));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   htmlstr_window u_window (
      .clock        (clock),
      .push         (win_push),
      .push_idx     (fill_ff[WIN_IDX_W-1:0]),
      .push_byte    (req_data.in_byte),
      .shift        (win_shift),
      .fill         (fill_ff),
      .stop_len     (eff_len),
      .stop_pattern ({stop_high_ff, stop_mid_ff, stop_low_ff}),
      .front_byte   (front_byte),
      .match        (match)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      skip_in       = skip_ff;
      tag_in        = tag_ff;
      head_in       = head_ff;
      started_in    = started_ff;
      stop_in       = stop_ff;
      pend_cnt_in   = pend_cnt_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      flush_idx_in  = flush_idx_ff;
      flush_char_in = flush_char_ff;
      win_push      = 1'b0;
      win_shift     = 1'b0;
      keep          = 1'b0;
      keep_char     = front_byte;
      ws_wr         = 1'b0;
      put           = 1'b0;
      put_item      = '0;
      fwd           = 1'b0;
      fwd_item      = held_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_data.in_last;
               if (!stop_ff && (fill_ff < FILL_W'(WINDOW_BYTES))) begin
                  win_push = 1'b1;
                  fill_in  = fill_ff + 1'b1;
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_due) begin
               win_shift = 1'b1;
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end else if (match.head_open) begin
                  head_in = 1'b1;
                  skip_in = SKIP_W'(OPEN_LEN - 1);
               end else if (match.head_close) begin
                  head_in = 1'b0;
                  skip_in = SKIP_W'(CLOSE_LEN - 1);
               end else if (match.quot) begin
                  keep      = 1'b1;
                  keep_char = CHAR_DQUOTE;
                  skip_in   = SKIP_W'(QUOT_LEN - 1);
               end else if (match.stop) begin
                  stop_in   = 1'b1;
                  win_shift = 1'b0;
               end else if (front_byte == CHAR_LT) begin
                  tag_in = 1'b1;
               end else if (front_byte == CHAR_GT) begin
                  tag_in = 1'b0;
               end else if (!tag_ff && !head_ff) begin
                  keep = 1'b1;
               end
               fill_in = win_shift ? (fill_ff - 1'b1) : '0;
               if (keep) begin
                  if (is_space(keep_char)) begin
                     if (started_ff) begin
                        if (pend_cnt_ff < WS_CNT_W'(WS_DEPTH)) begin
                           ws_wr       = 1'b1;
                           pend_cnt_in = pend_cnt_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end else begin
                     flush_char_in = keep_char;
                     flush_idx_in  = '0;
                     state_in      = ST_FLUSH;
                  end
               end
            end else if (out_free || (!held_valid_ff && !last_ff)) begin
               if (held_valid_ff) begin
                  fwd               = 1'b1;
                  fwd_item          = held_ff;
                  fwd_item.out_last = last_ff;
               end else if (last_ff) begin
                  fwd                  = 1'b1;
                  fwd_item.out_byte    = 8'h00;
                  fwd_item.has_byte    = 1'b0;
                  fwd_item.out_last    = 1'b1;
                  fwd_item.ws_overflow = ovf_ff;
               end
               held_valid_in = 1'b0;
               if (last_ff) begin
                  fill_in     = '0;
                  skip_in     = '0;
                  tag_in      = 1'b0;
                  head_in     = 1'b0;
                  started_in  = 1'b0;
                  stop_in     = 1'b0;
                  pend_cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff || out_free) begin
               put                  = 1'b1;
               put_item.has_byte    = 1'b1;
               put_item.out_last    = 1'b0;
               put_item.ws_overflow = ovf_ff;
               if (flush_idx_ff < pend_cnt_ff) begin
                  put_item.out_byte = ws_rd_ff;
                  flush_idx_in      = flush_idx_ff + 1'b1;
               end else begin
                  put_item.out_byte = flush_char_ff;
                  pend_cnt_in       = '0;
                  started_in        = 1'b1;
                  state_in          = ST_DECIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put) begin
         held_in       = put_item;
         held_valid_in = 1'b1;
         if (held_valid_ff) begin
            fwd      = 1'b1;
            fwd_item = held_ff;
         end
      end
   end

   assign rsp_valid_in = fwd || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = fwd ? fwd_item : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         skip_ff       <= '0;
         tag_ff        <= 1'b0;
         head_ff       <= 1'b0;
         started_ff    <= 1'b0;
         stop_ff       <= 1'b0;
         pend_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
         last_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         stop_low_ff   <= '0;
         stop_mid_ff   <= '0;
         stop_high_ff  <= '0;
         stop_len_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         skip_ff       <= skip_in;
         tag_ff        <= tag_in;
         head_ff       <= head_in;
         started_ff    <= started_in;
         stop_ff       <= stop_in;
         pend_cnt_ff   <= pend_cnt_in;
         ovf_ff        <= ovf_in;
         last_ff       <= last_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            case (reg_sel)
               REG_STOP_LOW:  stop_low_ff  <= pwdata;
               REG_STOP_MID:  stop_mid_ff  <= pwdata;
               REG_STOP_HIGH: stop_high_ff <= pwdata;
               REG_STOP_LEN:  stop_len_ff  <= pwdata[LEN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      rsp_ff        <= rsp_in;
      flush_idx_ff  <= flush_idx_in;
      flush_char_ff <= flush_char_in;
   end

   always_ff @(posedge clock) begin
      if (ws_wr) begin
         ws_mem[pend_cnt_ff[WS_IDX_W-1:0]] <= keep_char;
      end
      ws_rd_ff <= ws_mem[flush_idx_in[WS_IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `HTS_ASSERT_NEVER(a_stop_window_empty, clock, reset, stop_ff && (fill_ff != '0), "window holds bytes after stop marker")
   `HTS_ASSERT(a_accept_held_empty, clock, reset, req_accept |-> !held_valid_ff, "item accepted with a result still held")
   `HTS_ASSERT(a_overflow_sticky, clock, reset, ovf_ff |=> ovf_ff, "overflow flag cleared without reset")
   `HTS_ASSERT(a_pending_after_text, clock, reset, (pend_cnt_ff != '0) |-> started_ff, "spaces held before text started")
   `HTS_ASSERT(a_flush_in_range, clock, reset, (state_ff == ST_FLUSH) |-> (flush_idx_ff <= pend_cnt_ff), "flush index past held spaces")

endmodule
